/* design/interrupt_controller_mask_pending_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the interrupt controller mask/pending unit
// Clocked on i_clk; the checked form can be dropped for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_CONTROLLER_MASK_PENDING_UNIT_ASSERT_SVH
`define INTERRUPT_CONTROLLER_MASK_PENDING_UNIT_ASSERT_SVH

`ifndef SYNTH
// checked while out of reset
`define ICMP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("icmp assertion failed");
// checked on every edge, reset included
`define ICMP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("icmp assertion failed");
`else
`define ICMP_ASSERT(lbl, prop)
`define ICMP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* design/icmp_pkg.sv */
// ----------------------------------------------------------------------------
// icmp_pkg
// Types and constants shared by the mask/pending unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package icmp_pkg;

    localparam int NUM_SOURCES_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_BULK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    // access sizes; anything else is a word
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // register window, word aligned byte offsets
    localparam logic [11:0] REG_STATUS   = 12'h000;
    localparam logic [11:0] REG_MASK     = 12'h004;
    localparam logic [11:0] REG_MASK_SET = 12'h008;
    localparam logic [11:0] REG_MASK_CLR = 12'h00c;
    localparam logic [11:0] REG_UNMASKED = 12'h010;

    localparam logic [31:0] MASK_RESET  = 32'hffff_ffff;
    localparam logic [31:0] VALID_RESET = 32'hffff_ffff;
    localparam logic [31:0] LANE_BYTE   = 32'h0000_00ff;
    localparam logic [31:0] LANE_HALF   = 32'h0000_ffff;
    localparam logic [31:0] LANE_WORD   = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  source_index;
        logic        source_level;
        logic [31:0] bulk_select;
        logic [31:0] bulk_levels;
        logic [11:0] bus_offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
        logic [31:0] pending_now;
        logic [31:0] mask_now;
    } t_out_item;

    typedef struct packed {
        logic        wr_en;
        logic [31:0] data;
    } t_cfg_wr;

endpackage

`default_nettype wire

/* design/icmp_stream_if.sv */
// ----------------------------------------------------------------------------
// icmp_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface icmp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/icmp_core.sv */
// ----------------------------------------------------------------------------
// icmp_core
// Pending, mask and valid-source state with the combinational update and
// read logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "interrupt_controller_mask_pending_unit_assert.svh"

module icmp_core #(
    parameter int NUM_SOURCES = icmp_pkg::NUM_SOURCES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire icmp_pkg::t_cfg_wr   i_cfg,
    input  wire logic                i_go,
    input  wire icmp_pkg::t_in_item  i_item,
    output icmp_pkg::t_out_item      o_result
);
    import icmp_pkg::*;

    localparam logic [31:0] RANGE_BITS = (NUM_SOURCES >= 32) ? 32'hffff_ffff :
                                         32'((64'd1 << NUM_SOURCES) - 64'd1);

    logic [31:0] r_valid_src;
    logic [31:0] r_pending;
    logic [31:0] r_mask;
    logic        r_irq;

    logic [31:0] n_pending;
    logic [31:0] n_mask;
    logic        n_irq;

    logic [31:0] valid_set;
    logic [11:0] reg_addr;
    logic [4:0]  byte_shift;
    logic [31:0] line_bit;
    logic        line_hit;
    logic [31:0] bulk_sel;
    logic [31:0] rd_val;
    logic [31:0] rd_data;
    logic [31:0] wr_lanes;
    logic [31:0] lane_val;
    logic [31:0] cfg_pending;

    always_comb begin
        valid_set  = r_valid_src & RANGE_BITS;
        reg_addr   = {i_item.bus_offset[11:2], 2'b00};
        byte_shift = {i_item.bus_offset[1:0], 3'b000};
        line_bit   = 32'd1 << i_item.source_index[4:0];
        // indices of 32 and up never hit; range bits cover NUM_SOURCES
        line_hit   = !i_item.source_index[5] && ((valid_set & line_bit) != '0);
        bulk_sel   = i_item.bulk_select & valid_set;

        n_pending = r_pending;
        n_mask    = r_mask;
        rd_val    = '0;
        rd_data   = '0;
        wr_lanes  = LANE_WORD;
        lane_val  = '0;

        unique case (i_item.operation)
            OP_LINE: begin
                if (line_hit) begin
                    if (i_item.source_level) begin
                        n_pending = r_pending | line_bit;
                    end else begin
                        n_pending = r_pending & ~line_bit;
                    end
                end
            end
            OP_BULK: begin
                n_pending = (r_pending & ~bulk_sel) | (i_item.bulk_levels & bulk_sel);
            end
            OP_READ: begin
                unique case (reg_addr)
                    REG_STATUS:   rd_val = r_pending;
                    REG_MASK:     rd_val = r_mask;
                    REG_UNMASKED: rd_val = r_pending & ~r_mask;
                    default:      rd_val = '0;
                endcase
                rd_val = rd_val >> byte_shift;
                case (i_item.access_size)
                    SIZE_BYTE: rd_data = rd_val & LANE_BYTE;
                    SIZE_HALF: rd_data = rd_val & LANE_HALF;
                    default:   rd_data = rd_val;
                endcase
            end
            OP_WRITE: begin
                // word writes ignore the low offset bits
                case (i_item.access_size)
                    SIZE_BYTE: begin
                        wr_lanes = LANE_BYTE << byte_shift;
                        lane_val = (i_item.write_data << byte_shift) & wr_lanes;
                    end
                    SIZE_HALF: begin
                        wr_lanes = LANE_HALF << byte_shift;
                        lane_val = (i_item.write_data << byte_shift) & wr_lanes;
                    end
                    default: begin
                        wr_lanes = LANE_WORD;
                        lane_val = i_item.write_data;
                    end
                endcase
                unique case (reg_addr)
                    REG_MASK:     n_mask = (r_mask & ~wr_lanes) | lane_val;
                    REG_MASK_SET: n_mask = r_mask | lane_val;
                    REG_MASK_CLR: n_mask = r_mask & ~lane_val;
                    default:      n_mask = r_mask;
                endcase
            end
            default: begin
                n_pending = r_pending;
            end
        endcase

        n_irq       = (n_pending & ~n_mask) != '0;
        cfg_pending = r_pending & i_cfg.data & RANGE_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_src <= VALID_RESET;
            r_pending   <= '0;
            r_mask      <= MASK_RESET;
            r_irq       <= 1'b0;
        end else if (i_cfg.wr_en) begin
            r_valid_src <= i_cfg.data;
            r_pending   <= cfg_pending;
            r_irq       <= (cfg_pending & ~r_mask) != '0;
        end else if (i_go) begin
            r_pending <= n_pending;
            r_mask    <= n_mask;
            r_irq     <= n_irq;
        end
    end

    assign o_result = '{read_data:   rd_data,
                        irq_out:     n_irq,
                        pending_now: n_pending,
                        mask_now:    n_mask};

    `ICMP_ASSERT(a_pending_in_valid, (r_pending & ~(r_valid_src & RANGE_BITS)) == '0)
    `ICMP_ASSERT(a_irq_tracks_state, r_irq == ((r_pending & ~r_mask) != '0))
    `ICMP_ASSERT(a_read_keeps_state, i_go && !i_cfg.wr_en && i_item.operation == OP_READ |=> $stable(r_pending) && $stable(r_mask))
    `ICMP_ASSERT(a_cfg_no_mask_change, i_cfg.wr_en |=> $stable(r_mask))

endmodule

`default_nettype wire

/* design/interrupt_controller_mask_pending_unit.sv */
// ----------------------------------------------------------------------------
// interrupt_controller_mask_pending_unit
// 32-source level interrupt controller: pending/mask state, bus window and
// source line updates, one item per cycle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    icmp_pkg::t_in_item
//  o_out     out  valid/ready    icmp_pkg::t_out_item
//  i_cfg_*   in   write enable   valid_sources word
//
//  Each item is held in the input register, then in the result register.
//  Throughput is one item per cycle unless o_out stalls, set by the single
//  state update in icmp_core; both stages advance together when the result
//  is taken. i_in.ready drops only while both stages hold an item and o_out
//  stalls. Reset is synchronous; mask comes up all ones, pending, irq clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "interrupt_controller_mask_pending_unit_assert.svh"

module interrupt_controller_mask_pending_unit #(
    parameter int NUM_SOURCES = icmp_pkg::NUM_SOURCES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [31:0]  i_cfg_wr_data,
    icmp_stream_if.sink       i_in,
    icmp_stream_if.source     o_out
);
    import icmp_pkg::*;

    logic      r_item_vld;
    t_in_item  r_item;
    logic      r_out_vld;
    t_out_item r_out;

    logic      stage_go;
    t_out_item core_result;
    t_cfg_wr   cfg_wr;

    assign cfg_wr      = '{wr_en: i_cfg_wr_en, data: i_cfg_wr_data};
    assign stage_go    = r_item_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_item_vld || stage_go;
    assign o_out.valid = r_out_vld;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_item_vld <= i_in.valid;
            end
            if (stage_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.payload;
        end
        if (stage_go) begin
            r_out <= core_result;
        end
    end

    icmp_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_go     (stage_go),
        .i_item   (r_item),
        .o_result (core_result)
    );

    `ICMP_ASSERT(a_stall_only_when_full, !i_in.ready |-> r_item_vld && r_out_vld)
    `ICMP_ASSERT(a_go_fills_output, stage_go |=> r_out_vld)
    `ICMP_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_item_vld && !r_out_vld)

endmodule

`default_nettype wire
